// File: rtl/bdlm_pkg.sv
// Shared types and constants for the button debounce / LED mode block.
package bdlm_pkg;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_TICKS    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_HALF_PERIOD = 8'd1;

   localparam logic [7:0]  DEBOUNCE_TICKS_RESET    = 8'd20;
   localparam logic [15:0] BLINK_HALF_PERIOD_RESET = 16'd500;

   localparam logic [7:0]  DEBOUNCE_MAX = 8'hFF;
   localparam logic [15:0] BLINK_MAX    = 16'hFFFF;

   localparam logic [1:0] PHASE_WAIT_PRESS   = 2'd0;
   localparam logic [1:0] PHASE_DEBOUNCE     = 2'd1;
   localparam logic [1:0] PHASE_WAIT_RELEASE = 2'd2;

   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_ON    = 2'd1;
   localparam logic [1:0] MODE_BLINK = 2'd2;

   typedef struct packed {
      logic        press_pending;
      logic [1:0]  debounce_phase;
      logic [7:0]  debounce_elapsed;
      logic [15:0] blink_elapsed;
      logic        blink_lit;
      logic [1:0]  mode_now;
      logic        led_drive;
   } state_type;

   typedef struct packed {
      logic       mode_changed;
      logic [1:0] led_mode;
      logic       led_level;
   } result_type;

endpackage

// File: rtl/button_debounce_led_mode.sv
// Top level: button debounce and LED mode sequencer with stream ports.
//
// Each req item is one polling pass of the button: req_tdata carries the
// press edge flag, the released level and the millisecond tick flag. For
// every req item exactly one rsp item is produced, carrying the LED drive,
// the LED mode after the pass and a flag set when an accepted press
// changed the mode.
// Latency: the rsp item is valid the cycle after its req item is taken.
// Throughput: one item per clock unless the rsp register is stalled; the
// pass is one level of compare/increment logic from state to rsp registers.
// Stalls: the rsp register holds while rsp_tready is low; req_tready is
// high whenever the rsp register is empty or being drained this cycle, so
// a stalled receiver stalls the sender by exactly one item.
// Configuration: csr writes are always taken (index 0 debounce ticks,
// index 1 blink half period, other indexes ignored) and are meant to be
// issued while no item is in flight.
// Reset: synchronous, active high; clears all state, loads the register
// defaults (20 and 500 ticks) and empties the rsp register.
module button_debounce_led_mode (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [0] press_edge, [1] button_released, [2] tick_passed
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   // rsp_tdata: [0] led_level, [2:1] led_mode, [3] mode_changed
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bdlm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bdlm_pkg::CSR_DATA_W-1:0]    csr_data
);

   bdlm_pkg::state_type  state_ff, state_in;
   bdlm_pkg::result_type result_in;
   bdlm_pkg::result_type rsp_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           debounce_ticks_ff;
   logic [15:0]          blink_half_period_ff;
   logic                 req_take;

   assign csr_ready  = 1'b1;
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_take   = req_tvalid & req_tready;

   bdlm_step u_step (
      .cur_state         (state_ff),
      .press_edge        (req_tdata[0]),
      .button_released   (req_tdata[1]),
      .tick_passed       (req_tdata[2]),
      .debounce_ticks    (debounce_ticks_ff),
      .blink_half_period (blink_half_period_ff),
      .nxt_state         (state_in),
      .result            (result_in)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff    <= bdlm_pkg::DEBOUNCE_TICKS_RESET;
         blink_half_period_ff <= bdlm_pkg::BLINK_HALF_PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == bdlm_pkg::REG_DEBOUNCE_TICKS) begin
            debounce_ticks_ff <= csr_data[7:0];
         end
         if (csr_index == bdlm_pkg::REG_BLINK_HALF_PERIOD) begin
            blink_half_period_ff <= csr_data[15:0];
         end
      end
   end

   // pass state advances only on a taken item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff.mode_changed, rsp_data_ff.led_mode,
                        rsp_data_ff.led_level};

   // blink phase is only ever lit while in blink mode
   a_lit_only_blink: assert property (@(posedge clock) disable iff (reset)
      state_ff.blink_lit |-> (state_ff.mode_now == bdlm_pkg::MODE_BLINK))
      else $error("blink_lit set outside blink mode");

   // an accepted press moves debounce to wait-release and changes the mode
   a_accept_effect: assert property (@(posedge clock) disable iff (reset)
      (req_take && result_in.mode_changed) |=>
         ((state_ff.debounce_phase == bdlm_pkg::PHASE_WAIT_RELEASE) &&
          (state_ff.mode_now != $past(state_ff.mode_now))))
      else $error("accepted press did not update phase and mode");

   // reported rsp item matches the stored mode right after a take
   a_rsp_mode: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (rsp_tvalid && (rsp_data_ff.led_mode == state_ff.mode_now)))
      else $error("rsp mode differs from state mode");

endmodule

// File: rtl/bdlm_step.sv
// Next-state and result logic for one polling pass.
module bdlm_step (
   input  bdlm_pkg::state_type  cur_state,
   input  logic                 press_edge,
   input  logic                 button_released,
   input  logic                 tick_passed,
   input  logic [7:0]           debounce_ticks,
   input  logic [15:0]          blink_half_period,
   output bdlm_pkg::state_type  nxt_state,
   output bdlm_pkg::result_type result
);

   logic        pending;
   logic [7:0]  deb_cnt;
   logic [15:0] blink_cnt;
   logic        accepted;

   // saturating tick counters
   always_comb begin
      pending   = cur_state.press_pending | press_edge;
      deb_cnt   = cur_state.debounce_elapsed;
      blink_cnt = cur_state.blink_elapsed;
      if (tick_passed && (deb_cnt != bdlm_pkg::DEBOUNCE_MAX)) begin
         deb_cnt = deb_cnt + 8'd1;
      end
      if (tick_passed && (blink_cnt != bdlm_pkg::BLINK_MAX)) begin
         blink_cnt = blink_cnt + 16'd1;
      end
   end

   always_comb begin
      nxt_state                  = cur_state;
      nxt_state.press_pending    = pending;
      nxt_state.debounce_elapsed = deb_cnt;
      nxt_state.blink_elapsed    = blink_cnt;
      accepted                   = 1'b0;

      // debounce machine
      unique case (cur_state.debounce_phase)
         bdlm_pkg::PHASE_DEBOUNCE: begin
            if (button_released) begin
               nxt_state.debounce_phase = bdlm_pkg::PHASE_WAIT_PRESS;
            end else if (deb_cnt >= debounce_ticks) begin
               accepted                 = 1'b1;
               nxt_state.debounce_phase = bdlm_pkg::PHASE_WAIT_RELEASE;
            end
         end
         bdlm_pkg::PHASE_WAIT_RELEASE: begin
            if (button_released) begin
               nxt_state.debounce_phase = bdlm_pkg::PHASE_WAIT_PRESS;
            end
         end
         default: begin
            if (pending) begin
               nxt_state.press_pending    = 1'b0;
               nxt_state.debounce_elapsed = 8'd0;
               nxt_state.debounce_phase   = bdlm_pkg::PHASE_DEBOUNCE;
            end
         end
      endcase

      // LED machine
      unique case (cur_state.mode_now)
         bdlm_pkg::MODE_ON: begin
            nxt_state.led_drive = 1'b1;
            if (accepted) begin
               nxt_state.mode_now = bdlm_pkg::MODE_BLINK;
            end
         end
         bdlm_pkg::MODE_BLINK: begin
            if (blink_cnt >= blink_half_period) begin
               nxt_state.blink_elapsed = 16'd0;
               nxt_state.blink_lit     = ~cur_state.blink_lit;
               nxt_state.led_drive     = ~cur_state.blink_lit;
            end
            if (accepted) begin
               nxt_state.blink_lit = 1'b0;
               nxt_state.mode_now  = bdlm_pkg::MODE_OFF;
            end
         end
         default: begin
            nxt_state.led_drive = 1'b0;
            if (accepted) begin
               nxt_state.mode_now = bdlm_pkg::MODE_ON;
            end
         end
      endcase

      result.led_level    = nxt_state.led_drive;
      result.led_mode     = nxt_state.mode_now;
      result.mode_changed = accepted;
   end

endmodule

// File: sim/button_debounce_led_mode_test.sv
`timescale 1ns / 100ps
// Testbench for button_debounce_led_mode: directed and random passes checked by a predictor.
module button_debounce_led_mode_test;

   // Cycle budget: ~2k passes, worst-case stalls included, taken several times over.
   localparam int unsigned CYCLE_LIMIT  = 200_000;
   // Tick passes spent in on mode with a long half period.
   localparam int unsigned SOAK_PASSES  = 100;
   localparam int unsigned PHASE_PASSES = 240;

   // Predicts one LED result per polling pass and checks results in order.
   class led_mode_scoreboard;
      logic [7:0]           dbnc_limit;
      logic [15:0]          half_period;
      logic                 press_latched;
      logic [1:0]           phase;
      logic [7:0]           press_ticks;
      logic [15:0]          blink_ticks;
      logic                 blink_on;
      logic [1:0]           mode_now;
      logic                 led_on;
      bdlm_pkg::result_type led_results_due[$];
      int unsigned          mismatch_count;

      function new();
         dbnc_limit     = bdlm_pkg::DEBOUNCE_TICKS_RESET;
         half_period    = bdlm_pkg::BLINK_HALF_PERIOD_RESET;
         press_latched  = 1'b0;
         phase          = bdlm_pkg::PHASE_WAIT_PRESS;
         press_ticks    = '0;
         blink_ticks    = '0;
         blink_on       = 1'b0;
         mode_now       = bdlm_pkg::MODE_OFF;
         led_on         = 1'b0;
         mismatch_count = 0;
      endfunction

      function void write_register(logic [bdlm_pkg::CSR_INDEX_W-1:0] index,
                                   logic [bdlm_pkg::CSR_DATA_W-1:0] value);
         if (index == bdlm_pkg::REG_DEBOUNCE_TICKS) begin
            dbnc_limit = value[7:0];
         end else if (index == bdlm_pkg::REG_BLINK_HALF_PERIOD) begin
            half_period = value;
         end
      endfunction

      // pass_bits: [0] press edge, [1] released, [2] tick
      function void note_pass(logic [2:0] pass_bits);
         logic                 accepted;
         bdlm_pkg::result_type due;
         accepted = 1'b0;
         if (pass_bits[0]) press_latched = 1'b1;
         if (pass_bits[2]) begin
            if (press_ticks != bdlm_pkg::DEBOUNCE_MAX) press_ticks++;
            if (blink_ticks != bdlm_pkg::BLINK_MAX) blink_ticks++;
         end
         // debounce machine
         case (phase)
            bdlm_pkg::PHASE_DEBOUNCE: begin
               if (pass_bits[1]) begin
                  phase = bdlm_pkg::PHASE_WAIT_PRESS;
               end else if (press_ticks >= dbnc_limit) begin
                  accepted = 1'b1;
                  phase    = bdlm_pkg::PHASE_WAIT_RELEASE;
               end
            end
            bdlm_pkg::PHASE_WAIT_RELEASE: begin
               if (pass_bits[1]) phase = bdlm_pkg::PHASE_WAIT_PRESS;
            end
            default: begin
               if (press_latched) begin
                  press_latched = 1'b0;
                  press_ticks   = '0;
                  phase         = bdlm_pkg::PHASE_DEBOUNCE;
               end
            end
         endcase
         // LED machine; drive follows the mode held before this pass
         case (mode_now)
            bdlm_pkg::MODE_ON: begin
               led_on = 1'b1;
               if (accepted) mode_now = bdlm_pkg::MODE_BLINK;
            end
            bdlm_pkg::MODE_BLINK: begin
               if (blink_ticks >= half_period) begin
                  blink_ticks = '0;
                  blink_on    = !blink_on;
                  led_on      = blink_on;
               end
               if (accepted) begin
                  blink_on = 1'b0;
                  mode_now = bdlm_pkg::MODE_OFF;
               end
            end
            default: begin
               led_on = 1'b0;
               if (accepted) mode_now = bdlm_pkg::MODE_ON;
            end
         endcase
         due.led_level    = led_on;
         due.led_mode     = mode_now;
         due.mode_changed = accepted;
         led_results_due.push_back(due);
      endfunction

      function void compare_field(string name, logic [1:0] want, logic [1:0] seen);
         if (seen !== want) begin
            mismatch_count++;
            $error("%s: expected %0d, actual %0d", name, want, seen);
         end
      endfunction

      function void check_led_result(logic [7:0] rsp_item);
         bdlm_pkg::result_type seen;
         bdlm_pkg::result_type want;
         seen = rsp_item[3:0];
         if (led_results_due.size() == 0) begin
            mismatch_count++;
            $error("result item %h arrived with none expected", rsp_item);
            return;
         end
         want = led_results_due.pop_front();
         compare_field("led_level", {1'b0, want.led_level}, {1'b0, seen.led_level});
         compare_field("led_mode", want.led_mode, seen.led_mode);
         compare_field("mode_changed", {1'b0, want.mode_changed},
                       {1'b0, seen.mode_changed});
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [7:0]                       req_tdata;   // [0] press_edge, [1] button_released, [2] tick_passed
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [7:0]                       rsp_tdata;   // [0] led_level, [2:1] led_mode, [3] mode_changed
   logic                             csr_valid;
   logic                             csr_ready;
   logic [bdlm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bdlm_pkg::CSR_DATA_W-1:0]  csr_data;

   led_mode_scoreboard led_board;
   int unsigned        passes_sent;
   int unsigned        burst_left;
   int unsigned        rsp_hold_left;   // set by stimulus, counted down by the receiver

   button_debounce_led_mode dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: any hang or lost result ends here.
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("button_debounce_led_mode_test failed");
      $finish;
   end

   // Monitor: both handshakes are sampled at the rising edge, before the block updates.
   // The result of an item can never share its acceptance edge, so checking first is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) led_board.check_led_result(rsp_tdata);
         if (req_tvalid && req_tready) led_board.note_pass(req_tdata[2:0]);
      end
   end

   // Receiver: alternating random ready runs and short stalls,
   // overridden by a long hold-off whenever the stimulus asks for one.
   initial begin : receiver
      int unsigned run_left;
      logic        run_ready;
      rsp_tready = 1'b0;
      run_left   = 0;
      run_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left != 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               run_ready = !run_ready;
               run_left  = run_ready ? $urandom_range(1, 40) : $urandom_range(1, 6);
            end
            run_left--;
            rsp_tready <= run_ready;
         end
      end
   end

   // All driving tasks start and end at a falling edge with no pending
   // assignment in that step, so back-to-back calls never double-drive.

   // One polling pass; the sender runs in random bursts with random gaps.
   task automatic send_pass(input logic press_edge, input logic released, input logic tick);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, tick, released, press_edge};
      do @(posedge clock); while (!req_tready);
      passes_sent++;
      @(negedge clock);
      if (burst_left != 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (led_board.led_results_due.size() != 0) @(negedge clock);
      // margin after the last result is checked
      repeat (3) @(negedge clock);
   endtask

   // Only called with nothing in flight.
   task automatic write_csr(input logic [bdlm_pkg::CSR_INDEX_W-1:0] index,
                            input logic [bdlm_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      led_board.write_register(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Edge, hold long enough to count out (or release early), then release.
   // Stray edges while held get latched and start a later debounce.
   task automatic press_sequence();
      int unsigned limit;
      int unsigned hold_len;
      logic        bouncy;
      limit  = 32'(led_board.dbnc_limit);
      bouncy = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) hold_len = $urandom_range(0, limit);
      else hold_len = limit + limit / 4 + $urandom_range(1, 4);
      send_pass(1'b1, $urandom_range(0, 5) == 0, $urandom_range(0, 1) == 1);
      repeat (hold_len)
         send_pass($urandom_range(0, 15) == 0, bouncy && ($urandom_range(0, 9) == 0),
                   $urandom_range(0, 9) != 0);
      repeat ($urandom_range(1, 6))
         send_pass($urandom_range(0, 7) == 0, 1'b1, $urandom_range(0, 1) == 1);
   endtask

   task automatic noise_run();
      logic [2:0] bits;
      repeat ($urandom_range(1, 8)) begin
         bits = 3'($urandom_range(0, 7));
         send_pass(bits[0], bits[1], bits[2]);
      end
   endtask

   task automatic run_random_phase(input int unsigned pass_goal);
      int unsigned stop_at;
      stop_at = passes_sent + pass_goal;
      while (passes_sent < stop_at) begin
         if ($urandom_range(0, 9) < 7) press_sequence();
         else noise_run();
      end
   endtask

   // Needs a zero debounce time: every three passes accept one press.
   task automatic steer_to_mode(input logic [1:0] target);
      while (led_board.mode_now != target) begin
         send_pass(1'b1, 1'b0, 1'b0);
         send_pass(1'b0, 1'b0, 1'b0);
         send_pass(1'b0, 1'b1, 1'b0);
      end
   endtask

   initial begin : stimulus
      int unsigned      phase_no;
      logic [7:0]       dbnc;
      logic [15:0]      half;
      led_board     = new();
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      passes_sent   = 0;
      burst_left    = 0;
      rsp_hold_left = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // a couple of passes on the reset register values
      send_pass(1'b0, 1'b1, 1'b1);
      send_pass(1'b0, 1'b1, 1'b0);
      wait_drained();

      // directed: zero debounce time and zero half period
      write_csr(bdlm_pkg::REG_DEBOUNCE_TICKS, 16'd0);
      write_csr(bdlm_pkg::REG_BLINK_HALF_PERIOD, 16'd0);
      send_pass(1'b0, 1'b1, 1'b0);   // released, nothing latched
      send_pass(1'b1, 1'b0, 1'b0);   // edge consumed, debounce starts
      send_pass(1'b0, 1'b0, 1'b0);   // accepted at once: off -> on
      send_pass(1'b0, 1'b0, 1'b1);   // held, waiting for release
      send_pass(1'b1, 1'b0, 1'b1);   // edge while busy stays latched
      send_pass(1'b0, 1'b1, 1'b0);   // release
      send_pass(1'b0, 1'b1, 1'b0);   // latched edge starts debounce
      send_pass(1'b0, 1'b1, 1'b1);   // released during debounce: cancelled
      send_pass(1'b1, 1'b0, 1'b0);
      send_pass(1'b0, 1'b0, 1'b1);   // accepted: on -> blink
      send_pass(1'b0, 1'b0, 1'b0);   // toggles every pass
      send_pass(1'b0, 1'b1, 1'b1);
      send_pass(1'b1, 1'b1, 1'b0);   // edge together with release
      send_pass(1'b0, 1'b0, 1'b0);   // accepted: blink -> off
      send_pass(1'b0, 1'b0, 1'b0);   // off mode pulls the LED low
      send_pass(1'b0, 1'b1, 1'b0);   // release, LED stays low
      wait_drained();

      // indexes past the register map must be ignored
      write_csr(8'd2, 16'($urandom_range(0, 65535)));
      write_csr(8'hFF, 16'($urandom_range(0, 65535)));

      // random phases across several register settings, extremes included
      for (phase_no = 0; phase_no < 6; phase_no++) begin
         case (phase_no)
            0: begin dbnc = 8'd1; half = 16'd1; end
            1: begin dbnc = 8'($urandom_range(2, 6)); half = 16'($urandom_range(2, 8)); end
            2: begin dbnc = 8'd0; half = 16'd0; end
            3: begin dbnc = 8'($urandom_range(3, 12)); half = 16'($urandom_range(1, 40)); end
            4: begin
               dbnc = bdlm_pkg::DEBOUNCE_TICKS_RESET;
               half = bdlm_pkg::BLINK_HALF_PERIOD_RESET;
            end
            default: begin dbnc = bdlm_pkg::DEBOUNCE_MAX; half = bdlm_pkg::BLINK_MAX; end
         endcase
         // sender pauses here until every result is in
         wait_drained();
         // upper byte is junk for the 8-bit register
         write_csr(bdlm_pkg::REG_DEBOUNCE_TICKS, {8'($urandom_range(0, 255)), dbnc});
         write_csr(bdlm_pkg::REG_BLINK_HALF_PERIOD, half);
         // long receiver hold-off while the sender keeps offering items
         if (phase_no == 1) rsp_hold_left = 400;
         run_random_phase(PHASE_PASSES);
      end

      // Long half period: park in on mode and keep ticking; the blink
      // counter runs in every mode.
      wait_drained();
      write_csr(bdlm_pkg::REG_DEBOUNCE_TICKS, 16'd0);
      write_csr(bdlm_pkg::REG_BLINK_HALF_PERIOD, bdlm_pkg::BLINK_MAX);
      steer_to_mode(bdlm_pkg::MODE_ON);
      repeat (SOAK_PASSES) send_pass(1'b0, $urandom_range(0, 1) == 1, 1'b1);
      wait_drained();
      // longest debounce: accepted when the count reaches its max
      write_csr(bdlm_pkg::REG_DEBOUNCE_TICKS, {8'h00, bdlm_pkg::DEBOUNCE_MAX});
      send_pass(1'b1, 1'b0, 1'b0);
      repeat (int'(bdlm_pkg::DEBOUNCE_MAX) + 4) send_pass(1'b0, 1'b0, 1'b1);
      repeat (6) send_pass(1'b0, 1'b1, 1'b1);

      wait_drained();
      repeat (4) @(posedge clock);
      if (led_board.mismatch_count == 0) begin
         $display("button_debounce_led_mode_test passed");
      end else begin
         $display("button_debounce_led_mode_test failed");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/bdlm_pkg.sv
rtl/bdlm_step.sv
rtl/button_debounce_led_mode.sv
sim/button_debounce_led_mode_test.sv
